@@ rtl/sync_length_frame_deframer_core_assert.svh @@
// assertion macros for the frame deframer
// no dependencies; included by the modules that carry checks
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// check held off while reset is low
`define SLFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// check that also runs through reset
`define SLFD_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed during reset");

`else

`define SLFD_ASSERT(label, clk, rst_n, prop)
`define SLFD_ASSERT_RST(label, clk, prop)

`endif

`endif

@@ rtl/slfd_pkg.sv @@
// types and constants of the frame deframer
// no dependencies; used by the core and the testbench
`default_nettype none

package slfd_pkg;

    // frame layout
    localparam int unsigned HEADER_BYTES = 5;
    localparam logic [15:0] MIN_FRAME_LEN = 16'(HEADER_BYTES + 2);
    localparam logic [7:0]  SYNC_FIRST    = 8'h55;
    localparam logic [7:0]  SYNC_SECOND   = 8'hAA;

    // parser phase
    typedef enum logic [2:0] {
        PH_HUNT1  = 3'd0,
        PH_HUNT2  = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_TYPE   = 3'd4,
        PH_BODY   = 3'd5,
        PH_CHK_LO = 3'd6
    } t_phase;

    // result kind codes
    typedef enum logic [2:0] {
        KIND_TYPE      = 3'd0,
        KIND_PAYLOAD   = 3'd1,
        KIND_GOOD      = 3'd2,
        KIND_BAD_CHECK = 3'd3,
        KIND_BAD_LEN   = 3'd4
    } t_kind;

endpackage

`default_nettype wire

@@ rtl/slfd_chan_if.sv @@
// valid/ready channels of the frame deframer: received bytes in, results out
// depends on nothing; instantiated around sync_length_frame_deframer_core
`default_nettype none

// received byte channel
interface slfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result word channel
interface slfd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [15:0] payload_index;

    modport source (output valid, output kind, output value, output payload_index,
                    input ready);
    modport sink   (input valid, input kind, input value, input payload_index,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/sync_length_frame_deframer_core.sv @@
// sync/length/type frame deframer with LRC8 (or zero) checksum verdict
// depends on slfd_pkg, slfd_chan_if.sv and sync_length_frame_deframer_core_assert.svh
//
//   channel   dir  width  contents
//   i_rx      in   8      rx_byte, one received byte per word
//   o_res     out  27     kind(3), value(8), payload_index(16)
//   i_cfg_*   in   1      checksum_mode, write only
//
// one received word per cycle unless the result register stalls; each word gives zero or one result word
// in the cycle after acceptance, from the single parser state update feeding the result register
// reset (synchronous, active low) puts the parser in the hunt and empties the result
// register; checksum_mode resets to 1
// a stalled result register holds its word and input is taken only if that word
// leaves in the same cycle
`default_nettype none

`include "sync_length_frame_deframer_core_assert.svh"

module sync_length_frame_deframer_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_wr_en,
    input  wire logic   i_cfg_wr_data,
    slfd_in_if.sink     i_rx,
    slfd_out_if.source  o_res
);
    import slfd_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [15:0] r_count,  n_count;
    logic [15:0] r_length, n_length;
    logic [7:0]  r_xor,    n_xor;
    logic [7:0]  r_chk_hi, n_chk_hi;
    logic        r_mode;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [7:0]  r_out_value;
    logic [15:0] r_out_idx;

    logic        n_emit;
    t_kind       n_kind;
    logic [7:0]  n_value;
    logic [15:0] n_idx;

    logic        in_take;
    logic [7:0]  b;
    logic [15:0] check_start;
    logic [7:0]  expected_lo;

    // input taken whenever the result register is free or draining
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign in_take    = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;

    assign check_start = r_length - 16'd2;
    assign expected_lo = r_mode ? r_xor : 8'h00;

    // next parser state and result for the current byte
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_length = r_length;
        n_xor    = r_xor;
        n_chk_hi = r_chk_hi;
        n_emit   = 1'b0;
        n_kind   = KIND_TYPE;
        n_value  = 8'h00;
        n_idx    = 16'h0000;
        unique case (r_phase)
            PH_HUNT1: begin
                if (b == SYNC_FIRST) begin
                    n_xor   = b;
                    n_count = 16'd1;
                    n_phase = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (b == SYNC_SECOND) begin
                    n_xor   = r_xor ^ b;
                    n_count = 16'd2;
                    n_phase = PH_LEN_HI;
                end else begin
                    n_phase  = PH_HUNT1;
                    n_count  = '0;
                    n_length = '0;
                    n_xor    = '0;
                    n_chk_hi = '0;
                end
            end
            PH_LEN_HI: begin
                n_length = {b, 8'h00};
                n_xor    = r_xor ^ b;
                n_count  = 16'd3;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {r_length[15:8], b};
                n_xor    = r_xor ^ b;
                n_count  = 16'd4;
                n_phase  = PH_TYPE;
                // too short for header and checksum
                if ({r_length[15:8], b} < MIN_FRAME_LEN) begin
                    n_phase  = PH_HUNT1;
                    n_count  = '0;
                    n_length = '0;
                    n_xor    = '0;
                    n_chk_hi = '0;
                    n_emit   = 1'b1;
                    n_kind   = KIND_BAD_LEN;
                end
            end
            PH_TYPE: begin
                n_xor   = r_xor ^ b;
                n_count = 16'(HEADER_BYTES);
                n_phase = PH_BODY;
                n_emit  = 1'b1;
                n_kind  = KIND_TYPE;
                n_value = b;
            end
            PH_BODY: begin
                n_count = r_count + 16'd1;
                if (r_count < check_start) begin
                    n_xor   = r_xor ^ b;
                    n_emit  = 1'b1;
                    n_kind  = KIND_PAYLOAD;
                    n_value = b;
                    n_idx   = r_count - 16'(HEADER_BYTES);
                end else begin
                    // high checksum byte
                    n_chk_hi = b;
                    n_phase  = PH_CHK_LO;
                end
            end
            PH_CHK_LO: begin
                n_emit   = 1'b1;
                n_kind   = (r_chk_hi == 8'h00 && b == expected_lo) ? KIND_GOOD
                                                                    : KIND_BAD_CHECK;
                n_phase  = PH_HUNT1;
                n_count  = '0;
                n_length = '0;
                n_xor    = '0;
                n_chk_hi = '0;
            end
            default: begin
                n_phase  = PH_HUNT1;
                n_count  = '0;
                n_length = '0;
                n_xor    = '0;
                n_chk_hi = '0;
            end
        endcase
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT1;
            r_count  <= '0;
            r_length <= '0;
            r_xor    <= '0;
            r_chk_hi <= '0;
        end else if (in_take) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_length <= n_length;
            r_xor    <= n_xor;
            r_chk_hi <= n_chk_hi;
        end
    end

    // checksum mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= n_emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (in_take && n_emit) begin
            r_out_kind  <= n_kind;
            r_out_value <= n_value;
            r_out_idx   <= n_idx;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out_kind;
    assign o_res.value         = r_out_value;
    assign o_res.payload_index = r_out_idx;

    // checks
    `SLFD_ASSERT_RST(a_reset_empties, i_clk, !i_rst_n |=> !r_out_valid)
    `SLFD_ASSERT(a_type_then_body, i_clk, i_rst_n,
        (in_take && r_phase == PH_TYPE) |=>
        (r_phase == PH_BODY && r_out_valid && r_out_kind == KIND_TYPE))
    `SLFD_ASSERT(a_body_bounds, i_clk, i_rst_n,
        r_phase == PH_BODY |-> (r_count >= 16'(HEADER_BYTES) && r_length >= MIN_FRAME_LEN))
    `SLFD_ASSERT(a_hunt_clean, i_clk, i_rst_n,
        r_phase == PH_HUNT1 |-> (r_count == 16'd0 && r_xor == 8'h00 && r_length == 16'd0))
    `SLFD_ASSERT(a_index_only_payload, i_clk, i_rst_n,
        (r_out_valid && r_out_kind != KIND_PAYLOAD) |-> r_out_idx == 16'd0)

endmodule

`default_nettype wire

@@ tb/tb_sync_length_frame_deframer_core.sv @@
// testbench for sync_length_frame_deframer_core: frames, broken syncs, short lengths, noise
// depends on slfd_pkg, slfd_chan_if.sv and the core; self-checking against its own parser model
`timescale 1ns / 1ps

module tb_sync_length_frame_deframer_core;
    import slfd_pkg::*;

    // how the checksum of a generated frame is chosen
    typedef enum int {
        CHK_RIGHT,
        CHK_WRONG,
        CHK_ZERO,
        CHK_LRC
    } t_chk_choice;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [15:0] payload_index;
    } t_word;

    localparam int unsigned RANDOM_BYTES = 1600;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    slfd_in_if  rx_ch ();
    slfd_out_if res_ch ();

    sync_length_frame_deframer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx          (rx_ch),
        .o_res         (res_ch)
    );

    // parser model state
    t_phase      ph;
    logic [15:0] cnt;
    logic [15:0] flen;
    logic [15:0] rcheck;
    logic [7:0]  rxor;
    logic        mode_q;

    t_word expected_words[$];
    int    n_fail;
    int    parsed_bytes;
    bit    gaps_on;
    bit    stalls_on;
    int    stall_left;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    // idle length: mostly short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 16'($urandom_range(7, 20));
        if (r < 97) return 16'($urandom_range(21, 80));
        return 16'($urandom_range(81, 400));
    endfunction

    task automatic hunt_reset();
        ph     = PH_HUNT1;
        cnt    = 16'h0000;
        flen   = 16'h0000;
        rxor   = 8'h00;
        rcheck = 16'h0000;
    endtask

    // advance the parser model by one accepted byte, queue the result word it gives
    task automatic track_frame_byte(input logic [7:0] b);
        t_word       w;
        bit          hit;
        logic [15:0] want;
        hit = 1'b0;
        w   = '{KIND_TYPE, 8'h00, 16'h0000};
        if (ph != PH_HUNT1 || b == SYNC_FIRST) parsed_bytes++;
        case (ph)
            PH_HUNT1: begin
                if (b == SYNC_FIRST) begin
                    rxor = b;
                    cnt  = 16'd1;
                    ph   = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (b == SYNC_SECOND) begin
                    rxor ^= b;
                    cnt  = 16'd2;
                    ph   = PH_LEN_HI;
                end else begin
                    hunt_reset();
                end
            end
            PH_LEN_HI: begin
                flen = {b, 8'h00};
                rxor ^= b;
                cnt  = 16'd3;
                ph   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                flen[7:0] = b;
                rxor ^= b;
                cnt  = 16'd4;
                if (flen < MIN_FRAME_LEN) begin
                    hunt_reset();
                    w   = '{KIND_BAD_LEN, 8'h00, 16'h0000};
                    hit = 1'b1;
                end else begin
                    ph = PH_TYPE;
                end
            end
            PH_TYPE: begin
                rxor ^= b;
                cnt  = 16'(HEADER_BYTES);
                ph   = PH_BODY;
                w    = '{KIND_TYPE, b, 16'h0000};
                hit  = 1'b1;
            end
            PH_BODY: begin
                if (cnt < flen - 16'd2) begin
                    w    = '{KIND_PAYLOAD, b, cnt - 16'(HEADER_BYTES)};
                    hit  = 1'b1;
                    rxor ^= b;
                    cnt  = cnt + 16'd1;
                end else begin
                    rcheck = {b, 8'h00};
                    cnt    = cnt + 16'd1;
                    ph     = PH_CHK_LO;
                end
            end
            PH_CHK_LO: begin
                rcheck[7:0] = b;
                want = mode_q ? {8'h00, rxor} : 16'h0000;
                w    = '{(rcheck == want) ? KIND_GOOD : KIND_BAD_CHECK, 8'h00, 16'h0000};
                hit  = 1'b1;
                hunt_reset();
            end
            default: hunt_reset();
        endcase
        if (hit) expected_words.push_back(w);
    endtask

    // send one received word; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? pick_idle() : 0;
        if (gap > 0) begin
            rx_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        do @(posedge i_clk); while (!rx_ch.ready);
        track_frame_byte(b);
        @(negedge i_clk);
    endtask

    // hold the sender until every expected word has come and the core has settled
    task automatic wait_drained();
        rx_ch.valid = 1'b0;
        @(negedge i_clk);
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_checksum_mode(input logic m);
        wait_drained();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = m;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        mode_q        = m;
    endtask

    // whole frame: sync, length, then, unless the length is too short, type, random payload, checksum as chosen
    task automatic send_frame(input logic [15:0] len, input logic [7:0] typ,
                              input t_chk_choice how);
        logic [7:0]  lrc;
        logic [7:0]  pb;
        logic [15:0] chk;
        logic [15:0] right;
        int          n;
        lrc = SYNC_FIRST ^ SYNC_SECOND ^ len[15:8] ^ len[7:0];
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len < MIN_FRAME_LEN) return;
        send_byte(typ);
        lrc ^= typ;
        n = int'(len) - int'(MIN_FRAME_LEN);
        repeat (n) begin
            pb = 8'($urandom_range(0, 255));
            lrc ^= pb;
            send_byte(pb);
        end
        right = mode_q ? {8'h00, lrc} : 16'h0000;
        case (how)
            CHK_RIGHT: chk = right;
            CHK_ZERO:  chk = 16'h0000;
            CHK_LRC:   chk = {8'h00, lrc};
            default: begin
                chk = 16'($urandom_range(0, 65535));
                if (chk == right) chk ^= 16'h8000;
            end
        endcase
        send_byte(chk[15:8]);
        send_byte(chk[7:0]);
    endtask

    // result side stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready = 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            res_ch.ready = 1'b0;
            stall_left   = pick_idle();
        end else begin
            res_ch.ready = 1'b1;
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_words.size() == 0) begin
                if (n_fail < 10)
                    $display("unexpected word: kind %0d value %02h index %0d",
                             res_ch.kind, res_ch.value, res_ch.payload_index);
                n_fail++;
            end else begin
                w = expected_words.pop_front();
                if (res_ch.kind !== w.kind || res_ch.value !== w.value ||
                    res_ch.payload_index !== w.payload_index) begin
                    if (n_fail < 10)
                        $display("word mismatch: exp kind %0d value %02h index %0d,",
                                 w.kind, w.value, w.payload_index,
                                 " got kind %0d value %02h index %0d",
                                 res_ch.kind, res_ch.value, res_ch.payload_index);
                    n_fail++;
                end
            end
        end
    end

    // reset mode is LRC: empty payload and a short payload, both right
    task automatic test_lrc_frames();
        send_frame(MIN_FRAME_LEN, 8'h00, CHK_RIGHT);
        send_frame(16'd9, 8'hFF, CHK_RIGHT);
    endtask

    task automatic test_bad_checksum();
        send_frame(16'd8, 8'h5A, CHK_WRONG);
    endtask

    // repeated first sync is a failed second sync; the following AA is then ignored
    task automatic test_sync_slips();
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'hFF);
    endtask

    task automatic test_short_length();
        send_frame(16'd0, 8'h00, CHK_RIGHT);
        send_frame(MIN_FRAME_LEN - 16'd1, 8'h00, CHK_RIGHT);
    endtask

    // zero mode: zero checksum passes, the LRC fails
    task automatic test_zero_mode();
        set_checksum_mode(1'b0);
        send_frame(MIN_FRAME_LEN, 8'h81, CHK_ZERO);
        send_frame(MIN_FRAME_LEN, 8'h3C, CHK_LRC);
        set_checksum_mode(1'b1);
    endtask

    // mostly well-formed frames, with noise, broken syncs, short lengths and mode changes
    task automatic test_random_traffic();
        int          r;
        int          c;
        logic [7:0]  b;
        t_chk_choice how;
        while (parsed_bytes < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            gaps_on   = ($urandom_range(0, 4) != 0);
            stalls_on = ($urandom_range(0, 4) != 0);
            if (r < 70) begin
                c = $urandom_range(0, 99);
                if (c < 70)      how = CHK_RIGHT;
                else if (c < 85) how = CHK_WRONG;
                else if (c < 93) how = CHK_ZERO;
                else             how = CHK_LRC;
                send_frame(pick_frame_len(), 8'($urandom_range(0, 255)), how);
            end else if (r < 80) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else if (r < 88) begin
                b = 8'($urandom_range(0, 255));
                if (b == SYNC_SECOND) b = 8'h2A;
                send_byte(SYNC_FIRST);
                send_byte(b);
            end else if (r < 95) begin
                send_frame(16'($urandom_range(0, 6)), 8'h00, CHK_RIGHT);
            end else if (r < 98) begin
                set_checksum_mode(1'($urandom_range(0, 1)));
            end else begin
                wait_drained();
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready  = 1'b1;
        n_fail        = 0;
        parsed_bytes  = 0;
        stall_left    = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        mode_q        = 1'b1;
        hunt_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_lrc_frames();
        test_bad_checksum();
        test_sync_slips();
        test_short_length();
        test_zero_mode();
        wait_drained();
        parsed_bytes = 0;
        test_random_traffic();

        // drain and settle
        rx_ch.valid = 1'b0;
        stalls_on   = 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
